@@ rtl/core/ymhdr_pkg.sv @@
// ymhdr_pkg: shared types, constants and helpers of the ymodem header parser
// no dependencies; imported by every module of the block
package ymhdr_pkg;

  // most size characters taken before a size-too-long report
  localparam int unsigned MAX_SIZE_CHARS = 15;
  localparam int unsigned SizeCntW       = $clog2(MAX_SIZE_CHARS + 1);

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QueuePtrW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QueueCntW   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] NAME_LIMIT_RST = 8'd128;

  // ascii codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_NAME,
    PH_SIZE,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    NS_SKIP,
    NS_DIGITS,
    NS_STOP
  } num_stage_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NAME_LONG = 2'd1,
    STAT_SIZE_LONG = 2'd2,
    STAT_UNTERM    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_DIGIT,
    CMD_REPORT
  } cmd_kind_e;

  typedef enum logic {
    KIND_CHAR   = 1'b0,
    KIND_REPORT = 1'b1
  } out_kind_e;

  // one queued command: char to forward, digit to accumulate, or final report
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;      // name char, or the digit character
    logic [7:0] name_len;
    status_e    status;
    logic       neg;
  } cmd_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_FF) || (c == CH_BS) || (c == CH_CR);
  endfunction

endpackage

@@ rtl/core/ymhdr_if.sv @@
// ymhdr_if: valid/ready stream interfaces for the header parser
// input channel carries payload bytes, output channel carries result words
interface ymhdr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_end;

  modport source (output valid, output data_byte, output packet_end, input ready);
  modport sink (input valid, input data_byte, input packet_end, output ready);
endinterface

interface ymhdr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  name_char;
  logic [7:0]  name_length;
  logic [31:0] file_size;
  logic [1:0]  status;

  modport source (output valid, output kind, output name_char, output name_length,
                  output file_size, output status, input ready);
  modport sink (input valid, input kind, input name_char, input name_length,
                input file_size, input status, output ready);
endinterface

@@ rtl/core/ymhdr_front.sv @@
// ymhdr_front: accepts payload bytes, tracks the header phase and classifies
// each byte into a queue command; depends on ymhdr_pkg and ymhdr_in_if
module ymhdr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  ymhdr_in_if.sink          in_i,
  input  logic              full_i,
  output logic              push_o,
  output ymhdr_pkg::cmd_t   cmd_o
);
  import ymhdr_pkg::*;

  phase_e                phase_q, phase_d;
  num_stage_e            stage_q, stage_d;
  logic [7:0]            name_count_q, name_count_d;
  logic [SizeCntW-1:0]   size_count_q, size_count_d;
  logic                  neg_q, neg_d;
  logic [7:0]            name_limit_q;

  logic       accept;
  logic [7:0] c;
  logic       last;
  logic       digit;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign c          = in_i.data_byte;
  assign last       = in_i.packet_end;
  assign digit      = c inside {[CH_ZERO:CH_NINE]};

  always_comb begin
    phase_d      = phase_q;
    stage_d      = stage_q;
    name_count_d = name_count_q;
    size_count_d = size_count_q;
    neg_d        = neg_q;
    push_o       = 1'b0;
    cmd_o        = '{kind: CMD_CHAR, data: c, name_len: name_count_q,
                     status: STAT_OK, neg: neg_q};
    if (accept) begin
      case (phase_q)
        PH_NAME: begin
          if (c == CH_NUL) begin
            phase_d = PH_SIZE;
          end else if (name_count_q >= name_limit_q) begin
            push_o       = 1'b1;
            cmd_o.kind   = CMD_REPORT;
            cmd_o.status = STAT_NAME_LONG;
            phase_d      = PH_DONE;
          end else if (!last) begin
            push_o       = 1'b1;
            name_count_d = name_count_q + 8'd1;
          end
        end
        PH_SIZE: begin
          if (c == CH_NUL) begin
            push_o     = 1'b1;
            cmd_o.kind = CMD_REPORT;
            phase_d    = PH_DONE;
          end else if (size_count_q >= SizeCntW'(MAX_SIZE_CHARS)) begin
            push_o       = 1'b1;
            cmd_o.kind   = CMD_REPORT;
            cmd_o.status = STAT_SIZE_LONG;
            phase_d      = PH_DONE;
          end else begin
            size_count_d = size_count_q + SizeCntW'(1);
            case (stage_q)
              NS_SKIP: begin
                if (is_blank(c)) begin
                  stage_d = NS_SKIP;
                end else if ((c == CH_MINUS) || (c == CH_PLUS)) begin
                  neg_d   = (c == CH_MINUS);
                  stage_d = NS_DIGITS;
                end else if (digit) begin
                  push_o     = 1'b1;
                  cmd_o.kind = CMD_DIGIT;
                  stage_d    = NS_DIGITS;
                end else begin
                  stage_d = NS_STOP;
                end
              end
              NS_DIGITS: begin
                if (digit) begin
                  push_o     = 1'b1;
                  cmd_o.kind = CMD_DIGIT;
                end else begin
                  stage_d = NS_STOP;
                end
              end
              default: begin
                stage_d = stage_q;
              end
            endcase
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase

      if (last) begin
        // packet ends before any report: flag it; a pending digit no longer matters
        if (!(push_o && (cmd_o.kind == CMD_REPORT)) && (phase_q != PH_DONE)) begin
          push_o       = 1'b1;
          cmd_o.kind   = CMD_REPORT;
          cmd_o.status = STAT_UNTERM;
        end
        phase_d      = PH_NAME;
        stage_d      = NS_SKIP;
        name_count_d = '0;
        size_count_d = '0;
        neg_d        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_NAME;
      stage_q      <= NS_SKIP;
      name_count_q <= '0;
      size_count_q <= '0;
      neg_q        <= 1'b0;
      name_limit_q <= NAME_LIMIT_RST;
    end else begin
      phase_q      <= phase_d;
      stage_q      <= stage_d;
      name_count_q <= name_count_d;
      size_count_q <= size_count_d;
      neg_q        <= neg_d;
      if (cfg_we_i) begin
        name_limit_q <= cfg_wdata_i;
      end
    end
  end

endmodule

@@ rtl/core/ymhdr_queue.sv @@
// ymhdr_queue: short command queue between front and back
// depends on ymhdr_pkg for the command type and depth
module ymhdr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ymhdr_pkg::cmd_t   cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output ymhdr_pkg::cmd_t   head_o
);
  import ymhdr_pkg::*;

  cmd_t                 entries_q [QUEUE_DEPTH];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o       = (count_q == QueueCntW'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entries_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  function automatic logic [QueuePtrW-1:0] next_ptr(input logic [QueuePtrW-1:0] p);
    return (p == QueuePtrW'(QUEUE_DEPTH - 1)) ? '0 : p + QueuePtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QueueCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ rtl/core/ymhdr_back.sv @@
// ymhdr_back: runs queued commands, accumulates the decimal size and drives
// the output register; depends on ymhdr_pkg and ymhdr_out_if
module ymhdr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  ymhdr_pkg::cmd_t   head_i,
  output logic              pop_o,
  ymhdr_out_if.source       out_o
);
  import ymhdr_pkg::*;

  logic [31:0] total_q, total_d;
  logic        out_valid_q, out_valid_d;
  logic        kind_q, kind_d;
  logic [7:0]  char_q, char_d;
  logic [7:0]  len_q, len_d;
  logic [31:0] size_q, size_d;
  logic [1:0]  status_q, status_d;
  logic        slot_free;
  logic [31:0] times_ten;

  assign slot_free = !out_valid_q || out_o.ready;
  // digit commands only touch the accumulator, so they never wait on the output
  assign pop_o     = head_valid_i && ((head_i.kind == CMD_DIGIT) || slot_free);
  assign times_ten = {total_q[28:0], 3'b000} + {total_q[30:0], 1'b0};

  always_comb begin
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_o.ready;
    kind_d      = kind_q;
    char_d      = char_q;
    len_d       = len_q;
    size_d      = size_q;
    status_d    = status_q;
    if (pop_o) begin
      case (head_i.kind)
        CMD_DIGIT: begin
          // low nibble of an ascii digit is its value
          total_d = times_ten + {28'd0, head_i.data[3:0]};
        end
        CMD_CHAR: begin
          out_valid_d = 1'b1;
          kind_d      = KIND_CHAR;
          char_d      = head_i.data;
          len_d       = '0;
          size_d      = '0;
          status_d    = STAT_OK;
        end
        CMD_REPORT: begin
          out_valid_d = 1'b1;
          kind_d      = KIND_REPORT;
          char_d      = '0;
          len_d       = head_i.name_len;
          status_d    = head_i.status;
          if (head_i.status != STAT_OK) begin
            size_d = '0;
          end else if (head_i.neg) begin
            size_d = 32'd0 - total_q;
          end else begin
            size_d = total_q;
          end
          total_d = '0;
        end
        default: begin
          total_d = total_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    char_q   <= char_d;
    len_q    <= len_d;
    size_q   <= size_d;
    status_q <= status_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = kind_q;
  assign out_o.name_char   = char_q;
  assign out_o.name_length = len_q;
  assign out_o.file_size   = size_q;
  assign out_o.status      = status_q;

endmodule

@@ rtl/core/ymodem_header_name_size_parser.sv @@
// ymodem_header_name_size_parser: top level of the ymodem header parser
// depends on ymhdr_pkg, ymhdr_if, ymhdr_front, ymhdr_queue, ymhdr_back
//
// usage
//   in_i carries one payload byte of a header packet per word, with
//   packet_end on the last byte. out_o carries one word per filename char
//   (kind 0) and one final report (kind 1) with name length, size, status.
//   cfg_we_i/cfg_wdata_i write name_limit; write only while the block is idle.
// timing
//   a result word goes from the byte that causes it through the front
//   classifier into the command queue, then the back unit into the output
//   register. one byte per cycle is sustained unless the output stalls; the
//   size accumulator takes one multiply-by-ten add per digit per cycle.
// stall
//   when out_o.ready is low the output register holds, chars and reports
//   back up into the two-entry queue, and in_i.ready drops once it is full.
//   digits at the queue head keep draining even while the output stalls.
// reset
//   rst_ni clears parser state, the queue and the output valid; name_limit
//   returns to 128. no clearing pass is needed.
module ymodem_header_name_size_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  ymhdr_in_if.sink    in_i,
  ymhdr_out_if.source out_o
);
  import ymhdr_pkg::*;

  // front to queue
  logic push;
  cmd_t push_cmd;
  logic queue_full;

  // queue to back
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  // classify bytes and track header phase
  ymhdr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .full_i      (queue_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // decouples byte intake from output stalls
  ymhdr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (push_cmd),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_cmd)
  );

  // size accumulation and result words
  ymhdr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

@@ rtl/core/ymhdr_checker.sv @@
// ymhdr_checker: port-level assertions for the ymodem header parser
// depends on ymhdr_pkg; bound to ymodem_header_name_size_parser below
module ymhdr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [7:0]  out_name_char,
  input logic [7:0]  out_name_length,
  input logic [31:0] out_file_size,
  input logic [1:0]  out_status
);
  import ymhdr_pkg::*;

  // a stalled word stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_hold_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_name_char) &&
      $stable(out_name_length) && $stable(out_file_size) && $stable(out_status))
    else $error("output word changed while stalled");

  // char words carry nothing but the char
  a_char_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_kind == KIND_CHAR) |->
      (out_name_length == 8'd0) && (out_file_size == 32'd0) && (out_status == STAT_OK))
    else $error("char word with report fields set");

  // error reports carry no size and no char
  a_report_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_kind == KIND_REPORT) |->
      (out_name_char == 8'd0) && ((out_status == STAT_OK) || (out_file_size == 32'd0)))
    else $error("report word with stray fields");

endmodule

bind ymodem_header_name_size_parser ymhdr_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .out_kind        (out_o.kind),
  .out_name_char   (out_o.name_char),
  .out_name_length (out_o.name_length),
  .out_file_size   (out_o.file_size),
  .out_status      (out_o.status)
);
